@@ rtl/core/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddo_pkg
// shared types, constants and tables of the differential drive odometry
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int unsigned CordicStepsDef = 16;
    localparam logic [31:0] RstLin  = 32'd541596;
    localparam logic [31:0] RstAng  = 32'd663058;
    localparam logic [9:0]  RstRate = 10'd125;
    localparam logic signed [33:0] StartGain = 34'sd652032874;

    // constant divisors and their reciprocals scaled by 2^RecipShift
    localparam logic [19:0] DivLong    = 20'd1000000;
    localparam logic [19:0] DivShort   = 20'd15625;
    localparam logic [22:0] RecipLong  = 23'd68719;
    localparam logic [22:0] RecipShort = 23'd4398046;
    localparam int unsigned RecipShift = 36;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_SET_POSE = 2'd1;
    localparam logic [1:0] KIND_SET_HEAD = 2'd2;
    localparam logic [1:0] KIND_INVALID  = 2'd3;

    localparam logic [1:0] REG_LIN  = 2'd0;
    localparam logic [1:0] REG_ANG  = 2'd1;
    localparam logic [1:0] REG_RATE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_VL, S_VA, S_DIST, S_DH, S_DIV, S_COR, S_DX, S_DY, S_DONE
    } t_state;

    // cordic control between sequencer and rotator
    typedef struct packed {
        logic start;
        logic [31:0] angle;
    } t_cor_ctl;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/ddo_cordic.sv @@
// ----------------------------------------------------------------------------
// ddo_cordic
// iterative cordic rotator, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int unsigned CORDIC_STEPS = ddo_pkg::CordicStepsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ddo_pkg::t_cor_ctl i_ctl,
    output logic              o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    localparam int unsigned CW = $clog2(CORDIC_STEPS + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_i, n_i;
    logic              r_flip, n_flip;
    logic signed [33:0] r_x, n_x, r_y, n_y;
    logic signed [32:0] r_z, n_z;
    logic signed [33:0] w_xs, w_ys;
    logic [31:0]       w_a;

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_i    = r_i;
        n_flip = r_flip;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        w_a    = i_ctl.angle + 32'h40000000;
        if (i_ctl.start) begin
            n_flip = w_a[31];
            n_busy = 1'b1;
            n_i    = '0;
            n_x    = ddo_pkg::StartGain;
            n_y    = '0;
            n_z    = w_a[31] ? 33'(signed'(i_ctl.angle + 32'h80000000))
                             : 33'(signed'(i_ctl.angle));
        end else if (r_busy) begin
            if (r_z >= 0) begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - 33'(ddo_pkg::atan_lut(5'(r_i)));
            end else begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + 33'(ddo_pkg::atan_lut(5'(r_i)));
            end
            n_i = r_i + 1'b1;
            if (r_i == CW'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_i    <= n_i;
        end
        r_flip <= n_flip;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    // done the cycle after the last rotation, vector is final then
    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;
endmodule

@@ rtl/core/ddo_divider.sv @@
// ----------------------------------------------------------------------------
// ddo_divider
// divides a nonnegative 64-bit value by 1000000 or 15625, four 16-bit digits,
// each from a reciprocal estimate and one correction, in an estimate phase then a correction phase
// ----------------------------------------------------------------------------
module ddo_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_short,
    input  logic [63:0] i_num,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic        r_busy;
    logic        r_ph;
    logic        r_short;
    logic [1:0]  r_cnt;
    logic [63:0] r_num;
    logic [63:0] r_q;
    logic [19:0] r_rem;
    logic [35:0] r_v;
    logic [15:0] r_est;
    logic [19:0] w_den;
    logic [22:0] w_recip;
    logic [35:0] w_v;
    logic [58:0] w_prod;
    logic [35:0] w_r;
    logic        w_fix;
    logic [35:0] w_rn;
    logic [15:0] w_digit;

    assign w_den   = r_short ? ddo_pkg::DivShort : ddo_pkg::DivLong;
    assign w_recip = r_short ? ddo_pkg::RecipShort : ddo_pkg::RecipLong;

    // partial remainder with the next digit of the numerator
    assign w_v    = {r_rem, r_num[63:48]};
    assign w_prod = 59'(w_v) * 59'(w_recip);

    // estimate is low by at most one
    assign w_r     = r_v - 36'(r_est) * 36'(w_den);
    assign w_fix   = (w_r >= 36'(w_den));
    assign w_rn    = w_fix ? w_r - 36'(w_den) : w_r;
    assign w_digit = r_est + 16'(w_fix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_ph   <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_ph <= !r_ph;
            if (r_ph) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_num   <= i_num;
            r_rem   <= '0;
            r_q     <= '0;
            r_short <= i_short;
        end else if (r_busy) begin
            if (!r_ph) begin
                r_v   <= w_v;
                r_est <= w_prod[ddo_pkg::RecipShift +: 16];
                r_num <= {r_num[47:0], 16'd0};
            end else begin
                r_rem <= w_rn[19:0];
                r_q   <= {r_q[47:0], w_digit};
            end
        end
    end

    assign o_done = r_busy && r_ph && (r_cnt == 2'd3);
    assign o_quo  = {r_q[47:0], w_digit};
endmodule

@@ rtl/core/diff_drive_odometry.sv @@
// ----------------------------------------------------------------------------
// diff_drive_odometry
// dead-reckoning pose integrator for a two-wheel differential robot
// ----------------------------------------------------------------------------
// sequence: tick words run the multiply steps for linear and angular velocity,
//   then travel and its division by a constant, heading change and its
//   division by a constant, the cordic rotation and two position updates;
//   set and invalid words give their result the cycle after acceptance
// throughput: one word at a time, ready again the cycle after a result is taken
// reset: synchronous active low, clears pose to zero, loads default config
module diff_drive_odometry #(
    parameter int unsigned CORDIC_STEPS = ddo_pkg::CordicStepsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_left_count,
    input  logic signed [15:0] i_right_count,
    input  logic [19:0]        i_elapsed_us,
    input  logic signed [31:0] i_new_x,
    input  logic signed [31:0] i_new_y,
    input  logic [31:0]        i_new_heading,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_accepted,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic [31:0]        o_heading,
    output logic signed [31:0] o_lin_velocity,
    output logic signed [31:0] o_ang_velocity,
    output logic signed [31:0] o_delta_lin,
    output logic signed [31:0] o_delta_ang
);
    // configuration registers
    logic [31:0] r_lin, r_ang;
    logic [9:0]  r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin  <= ddo_pkg::RstLin;
            r_ang  <= ddo_pkg::RstAng;
            r_rate <= ddo_pkg::RstRate;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ddo_pkg::REG_LIN:  r_lin  <= i_cfg_data;
                ddo_pkg::REG_ANG:  r_ang  <= i_cfg_data;
                ddo_pkg::REG_RATE: r_rate <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    ddo_pkg::t_state r_state, n_state;

    // pose and per-word working registers
    logic [31:0]        r_x, r_y, r_h;
    logic [19:0]        r_e;
    logic signed [49:0] r_pl, r_pa;      // count difference or negated sum times scale
    logic signed [31:0] r_vl, r_va, r_dl, r_da;
    logic signed [63:0] r_prod;          // shared multiplier output
    logic signed [32:0] r_dist;          // travel can exceed 32 bits
    logic signed [31:0] r_dh;
    logic               r_acc;
    logic               r_div_ph;        // 0 dist division, 1 heading division
    logic               r_div_go;        // divider starts once the product is held

    // shared multiplier: one operand pair per state
    logic signed [49:0] w_ma;
    logic signed [20:0] w_mb;
    logic signed [63:0] w_mul;
    always_comb begin
        case (r_state)
            ddo_pkg::S_VL: begin w_ma = r_pl; w_mb = 21'(r_rate); end
            ddo_pkg::S_VA: begin w_ma = r_pa; w_mb = 21'(r_rate); end
            ddo_pkg::S_DIST: begin w_ma = 50'(r_vl); w_mb = 21'(r_e); end
            ddo_pkg::S_DH: begin w_ma = 50'(r_va); w_mb = 21'(r_e); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
        w_mul = 64'(w_ma) * 64'(w_mb);
    end

    // round half up then saturate a product divided by 2^16
    function automatic logic signed [31:0] rnd_sat16(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + 64'sd32768) >>> 16;
        if (t > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (t < -64'sd2147483648) return 32'sh80000000;
        return t[31:0];
    endfunction

    // divider sharing: signed round-to-nearest built from an unsigned divide
    logic        w_div_start;
    logic [63:0] w_div_num;
    logic [23:0] w_div_den;
    logic        w_div_done;
    logic [63:0] w_div_quo;
    logic signed [63:0] w_t;
    logic        w_neg;

    always_comb begin
        // floor((n + d/2)/d); negative t uses ceil of magnitude
        if (!r_div_ph) begin
            w_t = r_prod + 64'sd500000;
            w_div_den = 24'd1000000;
        end else begin
            w_t = r_prod + 64'sd7812;
            w_div_den = 24'd15625;
        end
        w_neg = w_t[63];
        w_div_num = w_neg ? 64'(-w_t) + 64'(w_div_den) - 64'd1 : 64'(w_t);
    end

    ddo_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_short (r_div_ph),
        .i_num   (w_div_num),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    logic signed [63:0] w_q;
    assign w_q = w_neg ? -signed'(w_div_quo) : signed'(w_div_quo);

    // cordic
    ddo_pkg::t_cor_ctl w_cor;
    logic              w_cor_done;
    logic signed [33:0] w_cos, w_sin;
    logic signed [33:0] r_cos, r_sin;

    assign w_cor.start = (r_state == ddo_pkg::S_DIV) && w_div_done && r_div_ph;
    assign w_cor.angle = r_h;

    ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cor),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // position step: dist * trig in Q2.30, rounded
    logic signed [65:0] w_pm;
    logic signed [65:0] w_pr;
    always_comb begin
        w_pm = 66'(r_dist) * 66'((r_state == ddo_pkg::S_DX) ? r_cos : r_sin);
        w_pr = (w_pm + 66'sd536870912) >>> 30;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ddo_pkg::S_IDLE:
                if (i_valid) n_state = (i_kind == ddo_pkg::KIND_TICK) ? ddo_pkg::S_VL
                                                                   : ddo_pkg::S_DONE;
            ddo_pkg::S_VL:   n_state = ddo_pkg::S_VA;
            ddo_pkg::S_VA:   n_state = ddo_pkg::S_DIST;
            ddo_pkg::S_DIST: n_state = ddo_pkg::S_DIV;
            ddo_pkg::S_DH:   n_state = ddo_pkg::S_DIV;
            ddo_pkg::S_DIV:
                if (w_div_done) n_state = r_div_ph ? ddo_pkg::S_COR : ddo_pkg::S_DH;
            ddo_pkg::S_COR:  if (w_cor_done) n_state = ddo_pkg::S_DX;
            ddo_pkg::S_DX:   n_state = ddo_pkg::S_DY;
            ddo_pkg::S_DY:   n_state = ddo_pkg::S_DONE;
            ddo_pkg::S_DONE: if (i_ready) n_state = ddo_pkg::S_IDLE;
            default:         n_state = ddo_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready     = (r_state == ddo_pkg::S_IDLE);
        o_valid     = (r_state == ddo_pkg::S_DONE);
        w_div_start = r_div_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ddo_pkg::S_IDLE;
            r_x      <= '0;
            r_y      <= '0;
            r_h      <= '0;
            r_div_ph <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= (r_state == ddo_pkg::S_DIST) || (r_state == ddo_pkg::S_DH);
            case (r_state)
                ddo_pkg::S_IDLE: if (i_valid) begin
                    r_div_ph <= 1'b0;
                    if (i_kind == ddo_pkg::KIND_SET_POSE) begin
                        r_x <= i_new_x;
                        r_y <= i_new_y;
                        r_h <= i_new_heading;
                    end else if (i_kind == ddo_pkg::KIND_SET_HEAD) begin
                        r_h <= i_new_heading;
                    end
                end
                ddo_pkg::S_DIV: if (w_div_done) r_div_ph <= 1'b1;
                ddo_pkg::S_DX: r_x <= r_x + w_pr[31:0];
                ddo_pkg::S_DY: begin
                    r_y <= r_y + w_pr[31:0];
                    r_h <= r_h + r_dh;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ddo_pkg::S_IDLE: if (i_valid) begin
                r_acc <= (i_kind != ddo_pkg::KIND_INVALID);
                r_e   <= i_elapsed_us;
                r_pl  <= 50'(i_kind == ddo_pkg::KIND_TICK ?
                         (17'(i_left_count) - 17'(i_right_count)) * $signed({1'b0, r_lin})
                         : 50'sd0);
                r_pa  <= 50'(i_kind == ddo_pkg::KIND_TICK ?
                         (-17'(i_left_count) - 17'(i_right_count)) * $signed({1'b0, r_ang})
                         : 50'sd0);
                r_vl  <= '0;
                r_va  <= '0;
                r_dl  <= '0;
                r_da  <= '0;
            end
            ddo_pkg::S_VL: begin
                r_dl <= rnd_sat16(64'(r_pl));
                r_vl <= rnd_sat16(w_mul);
            end
            ddo_pkg::S_VA: begin
                r_da <= rnd_sat16(64'(r_pa));
                r_va <= rnd_sat16(w_mul);
            end
            ddo_pkg::S_DIST: r_prod <= w_mul;
            ddo_pkg::S_DH:   r_prod <= w_mul <<< 10;
            ddo_pkg::S_DIV: if (w_div_done) begin
                if (!r_div_ph) r_dist <= w_q[32:0];
                else r_dh <= w_q[31:0];
            end
            ddo_pkg::S_COR: if (w_cor_done) begin
                r_cos <= w_cos;
                r_sin <= w_sin;
            end
            default: ;
        endcase
    end

    assign o_accepted     = r_acc;
    assign o_pos_x        = r_x;
    assign o_pos_y        = r_y;
    assign o_heading      = r_h;
    assign o_lin_velocity = r_vl;
    assign o_ang_velocity = r_va;
    assign o_delta_lin    = r_dl;
    assign o_delta_ang    = r_da;

`ifndef NO_ASSERTIONS
    // no word taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready during result");
    // a result held under backpressure keeps its x position and heading
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_pos_x) && $stable(o_heading))
        else $error("pose changed while stalled");
    // divider only started while the sequencer waits for it
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_state == ddo_pkg::S_DIV)) else $error("divider start");
`endif
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks diff_drive_odometry word by word against a cycle-free pose predictor
// under random idling on both channels and several register settings
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned Steps = 16;
    localparam int unsigned WatchLimit = 4000;
    localparam int unsigned RandPerPhase = 85;

    // arctangent per rotation step, binary angle units
    localparam logic [31:0] ArcTab [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D
    };

    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [19:0]        elapsed;
        logic [31:0]        nx;
        logic [31:0]        ny;
        logic [31:0]        nh;
    } t_word;

    typedef struct {
        logic        acc;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] h;
        logic [31:0] vl;
        logic [31:0] va;
        logic [31:0] dl;
        logic [31:0] da;
    } t_pose;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_kind = '0;
    logic signed [15:0] i_left_count = '0;
    logic signed [15:0] i_right_count = '0;
    logic [19:0] i_elapsed_us = '0;
    logic signed [31:0] i_new_x = '0;
    logic signed [31:0] i_new_y = '0;
    logic [31:0] i_new_heading = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_accepted;
    logic signed [31:0] o_pos_x, o_pos_y;
    logic [31:0] o_heading;
    logic signed [31:0] o_lin_velocity, o_ang_velocity, o_delta_lin, o_delta_ang;

    always #1 i_clk = ~i_clk;

    diff_drive_odometry u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_left_count(i_left_count), .i_right_count(i_right_count),
        .i_elapsed_us(i_elapsed_us), .i_new_x(i_new_x), .i_new_y(i_new_y),
        .i_new_heading(i_new_heading),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_accepted(o_accepted), .o_pos_x(o_pos_x), .o_pos_y(o_pos_y),
        .o_heading(o_heading), .o_lin_velocity(o_lin_velocity),
        .o_ang_velocity(o_ang_velocity), .o_delta_lin(o_delta_lin),
        .o_delta_ang(o_delta_ang)
    );

    // predictor copy of registers and pose
    logic [31:0] mdl_lin, mdl_ang;
    logic [9:0]  mdl_rate;
    logic [31:0] mdl_x, mdl_y, mdl_h;

    t_word pending_words[$];
    t_pose expected_poses[$];
    int errors = 0;
    int n_tick = 0, n_set = 0, n_bad = 0;
    bit quiet = 1'b0;
    int unsigned idle_cycles = 0;

    // round to nearest, ties toward plus infinity
    function automatic longint round_div(longint n, longint d);
        longint t;
        t = n + d / 2;
        if (t >= 0) return t / d;
        return -((-t + d - 1) / d);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // cos and sin of a binary angle, q2.30
    task automatic heading_cos_sin(input logic [31:0] ang, output longint c,
                                   output longint s);
        logic flip;
        logic [31:0] a;
        logic [31:0] sum;
        longint z, xv, yv, xs, ys;
        sum = ang + 32'h40000000;
        flip = sum[31];
        a = flip ? ang + 32'h80000000 : ang;
        z = longint'($signed(a));
        xv = 652032874;
        yv = 0;
        for (int i = 0; i < Steps; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (z >= 0) begin
                xv = xv - ys; yv = yv + xs; z = z - longint'(ArcTab[i]);
            end else begin
                xv = xv + ys; yv = yv - xs; z = z + longint'(ArcTab[i]);
            end
        end
        c = flip ? -xv : xv;
        s = flip ? -yv : yv;
    endtask

    // advance the pose by one word and queue the word the block must return
    task automatic odo_predict(input t_word w);
        t_pose p;
        longint sl, sa, pl, pa, dl, da, vl, va, travel, c, s, dx, dy, dh;
        dl = 0; da = 0; vl = 0; va = 0;
        p.acc = 1'b1;
        case (w.kind)
            ddo_pkg::KIND_TICK: begin
                sl = longint'(w.left) - longint'(w.right);
                sa = -longint'(w.left) - longint'(w.right);
                pl = sl * longint'(mdl_lin);
                pa = sa * longint'(mdl_ang);
                dl = clamp32(round_div(pl, 65536));
                da = clamp32(round_div(pa, 65536));
                vl = clamp32(round_div(pl * longint'(mdl_rate), 65536));
                va = clamp32(round_div(pa * longint'(mdl_rate), 65536));
                travel = round_div(vl * longint'(w.elapsed), 1000000);
                heading_cos_sin(mdl_h, c, s);
                dx = round_div(travel * c, 1073741824);
                dy = round_div(travel * s, 1073741824);
                dh = round_div(va * longint'(w.elapsed) * 1024, 15625);
                mdl_x = mdl_x + dx[31:0];
                mdl_y = mdl_y + dy[31:0];
                mdl_h = mdl_h + dh[31:0];
                n_tick++;
            end
            ddo_pkg::KIND_SET_POSE: begin
                mdl_x = w.nx; mdl_y = w.ny; mdl_h = w.nh;
                n_set++;
            end
            ddo_pkg::KIND_SET_HEAD: begin
                mdl_h = w.nh;
                n_set++;
            end
            default: begin
                p.acc = 1'b0;
                n_bad++;
            end
        endcase
        p.x = mdl_x; p.y = mdl_y; p.h = mdl_h;
        p.vl = vl[31:0]; p.va = va[31:0]; p.dl = dl[31:0]; p.da = da[31:0];
        expected_poses.push_back(p);
    endtask

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // driver: one nonblocking update of valid per edge
    int drv_gap = 0;
    always @(posedge i_clk) begin
        t_word w;
        logic nxt_valid;
        if (i_rst_n) begin
            nxt_valid = i_valid;
            if (i_valid && o_ready) begin
                w.kind = i_kind; w.left = i_left_count; w.right = i_right_count;
                w.elapsed = i_elapsed_us; w.nx = i_new_x; w.ny = i_new_y;
                w.nh = i_new_heading;
                odo_predict(w);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_words.size() != 0) begin
                    if (!quiet && $urandom_range(0, 4) == 0) begin
                        drv_gap = $urandom_range(1, 6);
                    end else begin
                        w = pending_words.pop_front();
                        i_kind <= w.kind;
                        i_left_count <= w.left;
                        i_right_count <= w.right;
                        i_elapsed_us <= w.elapsed;
                        i_new_x <= w.nx;
                        i_new_y <= w.ny;
                        i_new_heading <= w.nh;
                        nxt_valid = 1'b1;
                    end
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // monitor: compare each result word with the oldest prediction
    int mon_gap = 0;
    always @(posedge i_clk) begin
        t_pose p;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_poses.size() == 0) begin
                    $display("unexpected result word at %0t", $realtime);
                    errors++;
                end else begin
                    p = expected_poses.pop_front();
                    if (o_accepted !== p.acc)
                        report("accepted", 32'(o_accepted), 32'(p.acc));
                    if (o_pos_x !== p.x) report("pos_x", o_pos_x, p.x);
                    if (o_pos_y !== p.y) report("pos_y", o_pos_y, p.y);
                    if (o_heading !== p.h) report("heading", o_heading, p.h);
                    if (o_lin_velocity !== p.vl) report("lin_velocity", o_lin_velocity, p.vl);
                    if (o_ang_velocity !== p.va) report("ang_velocity", o_ang_velocity, p.va);
                    if (o_delta_lin !== p.dl) report("delta_lin", o_delta_lin, p.dl);
                    if (o_delta_ang !== p.da) report("delta_ang", o_delta_ang, p.da);
                end
            end
            // receiver stalls in bursts
            if (mon_gap > 0) begin
                mon_gap--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                mon_gap = $urandom_range(0, 5);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("watchdog: no handshake for %0d cycles", WatchLimit);
            $display("diff_drive_odometry regression: fail");
            $finish;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            ddo_pkg::REG_LIN:  mdl_lin = data;
            ddo_pkg::REG_ANG:  mdl_ang = data;
            ddo_pkg::REG_RATE: mdl_rate = data[9:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_tick(input int l, input int r, input int e);
        t_word w;
        w.kind = ddo_pkg::KIND_TICK; w.left = 16'(l); w.right = 16'(r);
        w.elapsed = 20'(e);
        w.nx = $urandom; w.ny = $urandom; w.nh = $urandom;
        pending_words.push_back(w);
    endtask

    task automatic push_set(input logic [1:0] k, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] h);
        t_word w;
        w.kind = k; w.left = 16'($urandom); w.right = 16'($urandom);
        w.elapsed = 20'($urandom);
        w.nx = x; w.ny = y; w.nh = h;
        pending_words.push_back(w);
    endtask

    // mostly plausible motion, some full-range noise and pose loads
    task automatic push_random;
        int sel, l, r, e;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            if ($urandom_range(0, 4) == 0) begin
                l = $signed(16'($urandom)); r = $signed(16'($urandom));
            end else begin
                l = $urandom_range(0, 400) - 200; r = $urandom_range(0, 400) - 200;
            end
            e = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1048575)
                                            : $urandom_range(7000, 9500);
            push_tick(l, r, e);
        end else if (sel < 80) begin
            push_set(ddo_pkg::KIND_SET_POSE, $urandom, $urandom, $urandom);
        end else if (sel < 90) begin
            push_set(ddo_pkg::KIND_SET_HEAD, $urandom, $urandom, $urandom);
        end else begin
            push_set(ddo_pkg::KIND_INVALID, $urandom, $urandom, $urandom);
        end
    endtask

    // wait until every word was returned, then let the block settle
    task automatic drain;
        while (pending_words.size() != 0 || i_valid || expected_poses.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        mdl_lin = ddo_pkg::RstLin; mdl_ang = ddo_pkg::RstAng; mdl_rate = ddo_pkg::RstRate;
        mdl_x = '0; mdl_y = '0; mdl_h = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset settings
        push_tick(0, 0, 0);
        push_tick(100, -100, 8333);
        push_tick(-50, -50, 8333);
        push_tick(32767, -32768, 1048575);
        push_tick(-32768, 32767, 1048575);
        push_tick(-32768, -32768, 1048575);
        push_tick(32767, 32767, 0);
        push_set(ddo_pkg::KIND_SET_HEAD, 0, 0, 32'h40000000);
        push_tick(200, -200, 8333);
        push_set(ddo_pkg::KIND_SET_HEAD, 0, 0, 32'hC0000000);
        push_tick(200, -200, 8333);
        push_set(ddo_pkg::KIND_SET_HEAD, 0, 0, 32'h80000000);
        push_tick(200, -200, 8333);
        push_set(ddo_pkg::KIND_SET_HEAD, 0, 0, 32'hBFFFFFFF);
        push_tick(200, -200, 8333);
        push_set(ddo_pkg::KIND_SET_POSE, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        push_tick(30000, -30000, 1048575);
        push_set(ddo_pkg::KIND_SET_POSE, 32'h80000000, 32'h7FFFFFFF, 32'h0);
        push_set(ddo_pkg::KIND_INVALID, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        push_set(ddo_pkg::KIND_INVALID, 0, 0, 0);
        push_set(ddo_pkg::KIND_SET_POSE, 0, 0, 0);
        drain();

        for (int ph = 1; ph <= 5; ph++) begin
            case (ph)
                1: begin
                    cfg_write(ddo_pkg::REG_LIN, 32'hFFFFFFFF);
                    cfg_write(ddo_pkg::REG_ANG, 32'hFFFFFFFF);
                    cfg_write(ddo_pkg::REG_RATE, 32'd1000);
                end
                2: begin
                    cfg_write(ddo_pkg::REG_LIN, 32'd0);
                    cfg_write(ddo_pkg::REG_ANG, 32'd0);
                    cfg_write(ddo_pkg::REG_RATE, 32'd1);
                end
                3: begin
                    // rate zero leaves the robot standing
                    cfg_write(ddo_pkg::REG_LIN, $urandom);
                    cfg_write(ddo_pkg::REG_ANG, $urandom_range(0, 2000000));
                    cfg_write(ddo_pkg::REG_RATE, $urandom & 32'hFFFFFC00);
                end
                4: begin
                    // rate above the nominal range is used as given
                    cfg_write(ddo_pkg::REG_LIN, $urandom_range(0, 4000000));
                    cfg_write(ddo_pkg::REG_ANG, $urandom);
                    cfg_write(ddo_pkg::REG_RATE, 32'd1023);
                end
                default: begin
                    cfg_write(ddo_pkg::REG_LIN, ddo_pkg::RstLin);
                    cfg_write(ddo_pkg::REG_ANG, ddo_pkg::RstAng);
                    cfg_write(ddo_pkg::REG_RATE, $urandom | 32'h0000007D);
                    quiet = 1'b1;
                end
            endcase
            push_tick(32767, -32768, 1048575);
            push_tick(-32768, -32768, 1048575);
            for (int k = 0; k < RandPerPhase; k++) push_random();
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (expected_poses.size() != 0) begin
            $display("%0d result words never arrived", expected_poses.size());
            errors++;
        end
        $display("covered %0d ticks, %0d pose loads, %0d rejected words over 6 settings",
                 n_tick, n_set, n_bad);
        $display("saturating and zero gains, rates 0 to 1023, %0d mismatches", errors);
        if (errors == 0) begin
            $display("diff_drive_odometry regression: pass");
        end else begin
            $display("diff_drive_odometry regression: fail");
        end
        $finish;
    end

endmodule
